>>> src/upd_pkg.sv
package upd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'd39;

   // Result queue between the decoder and the output register.
   localparam int FifoDepth = 8;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);
   localparam int MaxResults = 3;
   localparam int NumW      = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_query;
   } result_type;

   typedef struct packed {
      logic [NumW-1:0] num;
      result_type [MaxResults-1:0] res;
   } bundle_type;

   // Value of an uppercase hex digit; valid is low for any other byte.
   function automatic logic [4:0] upper_hex(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - "0")};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic is_reserved(input logic [7:0] code);
      logic r;
      case (code)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
         8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> src/upd_decode.sv
module upd_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   output upd_pkg::bundle_type bundle
);

   upd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         first_ff, first_in;

   logic [4:0]            lo_hex;
   logic [7:0]            code;
   upd_pkg::result_type   tail_res;
   logic                  tail_has;
   upd_pkg::phase_type    tail_phase;
   logic                  pct_ok;

   assign lo_hex = upd_pkg::upper_hex(in_byte);
   // The held first digit is '2' to '5', so its low nibble is its value.
   assign code   = {first_ff[3:0], lo_hex[3:0]};
   assign pct_ok = (in_byte >= "2") && (in_byte <= "5");

   // Handling of a byte seen outside an escape.
   always_comb begin
      tail_res.out_byte     = in_byte;
      tail_res.end_of_query = 1'b0;
      tail_has              = 1'b1;
      tail_phase            = upd_pkg::PH_IDLE;
      if (in_byte == upd_pkg::CH_SPACE) begin
         tail_res.out_byte     = 8'd0;
         tail_res.end_of_query = 1'b1;
      end else if (in_byte == upd_pkg::CH_PERCENT) begin
         tail_has   = 1'b0;
         tail_phase = upd_pkg::PH_PCT;
      end else if (in_byte == upd_pkg::CH_PLUS) begin
         tail_res.out_byte = upd_pkg::CH_SPACE;
      end
   end

   always_comb begin
      upd_pkg::result_type pct_res;
      upd_pkg::result_type dig_res;
      pct_res.out_byte     = upd_pkg::CH_PERCENT;
      pct_res.end_of_query = 1'b0;
      dig_res.out_byte     = first_ff;
      dig_res.end_of_query = 1'b0;
      bundle.res = {tail_res, tail_res, tail_res};
      bundle.num = upd_pkg::NumW'(tail_has);
      phase_in   = tail_phase;
      first_in   = first_ff;
      case (phase_ff)
         upd_pkg::PH_PCT: begin
            if (pct_ok) begin
               bundle.num = '0;
               phase_in   = upd_pkg::PH_DIGIT;
               first_in   = in_byte;
            end else begin
               bundle.res[0] = pct_res;
               bundle.res[1] = tail_res;
               bundle.num    = upd_pkg::NumW'(1 + int'(tail_has));
            end
         end
         upd_pkg::PH_DIGIT: begin
            if (lo_hex[4] && upd_pkg::is_reserved(code)) begin
               bundle.res[0].out_byte     = code;
               bundle.res[0].end_of_query = 1'b0;
               bundle.num                 = upd_pkg::NumW'(1);
               phase_in                   = upd_pkg::PH_IDLE;
            end else begin
               bundle.res[0] = pct_res;
               bundle.res[1] = dig_res;
               bundle.res[2] = tail_res;
               bundle.num    = upd_pkg::NumW'(2 + int'(tail_has));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_IDLE;
         first_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> src/url_percent_escape_decoder.sv
// URL query decoder, one raw byte per item on the req_ channel.
// Each accepted byte yields zero to three decoded items on the rsp_ channel:
// plain bytes pass, '+' becomes a space, a '%' escape of a reserved code
// becomes its byte, and a broken escape comes out verbatim. A space ends the
// query: pending escape bytes are flushed, then an item with rsp_tlast high
// and data zero marks the end.
// A byte's results enter the queue at the edge that accepts it, and the
// first one then moves from the queue to the output register once that
// register is empty or being taken. Throughput: one byte per cycle while each
// byte yields at most one result and the receiver does not stall; the rsp_
// side drains one item per cycle while rsp_tready is high, so bytes that flush
// two or three results slow the input until the eight-entry result queue
// drains. req_tready is low while the queue holds more than five items.
// A stalled receiver holds rsp_tdata and rsp_tlast steady; the queue absorbs
// further results until it holds more than five items, then req_tready drops.
// Reset (synchronous, active high) empties the queue and the output register
// and returns the decoder to idle with no escape pending.
module url_percent_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // end_of_query
);

   upd_pkg::bundle_type bundle;
   logic                accept;

   upd_pkg::result_type [upd_pkg::FifoDepth-1:0] queue_ff;
   logic [upd_pkg::FifoAw-1:0] head_ff, head_in;
   logic [upd_pkg::FifoAw-1:0] tail_ff, tail_in;
   logic [upd_pkg::CntW-1:0]   count_ff, count_in;
   logic                       out_valid_ff, out_valid_in;
   upd_pkg::result_type        out_ff;
   logic                       load;
   logic [upd_pkg::NumW-1:0]   push_num;

   assign req_tready = (count_ff <= upd_pkg::CntW'(upd_pkg::FifoDepth - upd_pkg::MaxResults));
   assign accept     = req_tvalid && req_tready;

   upd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .bundle  (bundle)
   );

   assign push_num = accept ? bundle.num : '0;
   assign load     = (count_ff != '0) && (!out_valid_ff || rsp_tready);

   assign head_in  = load ? head_ff + upd_pkg::FifoAw'(1) : head_ff;
   assign tail_in  = tail_ff + upd_pkg::FifoAw'(push_num);
   assign count_in = count_ff + upd_pkg::CntW'(push_num) - upd_pkg::CntW'(load);
   assign out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Results of one byte land in consecutive queue entries.
   always_ff @(posedge clock) begin
      for (int k = 0; k < upd_pkg::MaxResults; k++) begin
         if (upd_pkg::NumW'(k) < push_num) begin
            queue_ff[tail_ff + upd_pkg::FifoAw'(k)] <= bundle.res[k];
         end
      end
      if (load) begin
         out_ff <= queue_ff[head_ff];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tlast  = out_ff.end_of_query;

endmodule

>>> src/upd_checker.sv
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result item holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // The end-of-query item always carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'd0)
      else $error("end-of-query item with nonzero data");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   assert property (@(posedge clock) reset |=> req_tready)
      else $error("req_tready low after reset");

endmodule

bind url_percent_escape_decoder upd_checker u_upd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> bench/query_decode_checker.sv
`timescale 1ns / 1ps

module query_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         awaited_count
);

   localparam logic [7:0] ReservedCodes [19] = '{
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
      8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D
   };

   upd_pkg::result_type decoded_bytes_q[$];
   upd_pkg::phase_type  esc_phase = upd_pkg::PH_IDLE;
   logic [7:0] held_digit = 8'd0;
   int         errors_seen = 0;
   int         queued_n = 0;

   assign mismatch_count = errors_seen;
   assign awaited_count  = queued_n;

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - int'(8'h30);
      end
      if (c >= "A" && c <= "F") begin
         return int'(c) - int'(8'h41) + 10;
      end
      return -1;
   endfunction

   function automatic bit in_reserved_set(input logic [7:0] code);
      for (int k = 0; k < 19; k++) begin
         if (ReservedCodes[k] == code) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic push_decoded(input logic [7:0] value, input logic last);
      upd_pkg::result_type r;
      r.out_byte     = value;
      r.end_of_query = last;
      decoded_bytes_q.push_back(r);
   endtask

   // A byte seen with no escape pending, or left over from a broken escape.
   task automatic decode_plain_byte(input logic [7:0] b);
      if (b == upd_pkg::CH_SPACE) begin
         esc_phase = upd_pkg::PH_IDLE;
         push_decoded(8'd0, 1'b1);
      end else if (b == upd_pkg::CH_PERCENT) begin
         esc_phase = upd_pkg::PH_PCT;
      end else begin
         esc_phase = upd_pkg::PH_IDLE;
         push_decoded((b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b, 1'b0);
      end
   endtask

   task automatic decode_query_byte(input logic [7:0] b);
      int hi;
      int lo;
      logic [7:0] code;
      case (esc_phase)
         upd_pkg::PH_PCT: begin
            if (b >= "2" && b <= "5") begin
               held_digit = b;
               esc_phase  = upd_pkg::PH_DIGIT;
            end else begin
               push_decoded(upd_pkg::CH_PERCENT, 1'b0);
               decode_plain_byte(b);
            end
         end
         upd_pkg::PH_DIGIT: begin
            hi   = hex_digit_value(held_digit);
            lo   = hex_digit_value(b);
            code = 8'(hi * 16 + lo);
            if (hi >= 0 && lo >= 0 && in_reserved_set(code)) begin
               esc_phase = upd_pkg::PH_IDLE;
               push_decoded(code, 1'b0);
            end else begin
               push_decoded(upd_pkg::CH_PERCENT, 1'b0);
               push_decoded(held_digit, 1'b0);
               decode_plain_byte(b);
            end
         end
         default: begin
            decode_plain_byte(b);
         end
      endcase
   endtask

   always @(posedge clock) begin
      upd_pkg::result_type want;
      if (reset) begin
         esc_phase  = upd_pkg::PH_IDLE;
         held_digit = 8'd0;
         decoded_bytes_q.delete();
      end else begin
         // A byte's results reach the output only through the queue and the output
         // register, so predicting first never lets a result overtake its expectation.
         if (req_tvalid && req_tready) begin
            decode_query_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_bytes_q.size() == 0) begin
               $error("unexpected item: out_byte %h end_of_query %b", rsp_tdata, rsp_tlast);
               errors_seen++;
            end else begin
               want = decoded_bytes_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_tdata);
                  errors_seen++;
               end
               if (rsp_tlast !== want.end_of_query) begin
                  $error("end_of_query expected %b actual %b", want.end_of_query,
                         rsp_tlast);
                  errors_seen++;
               end
            end
         end
      end
      queued_n = decoded_bytes_q.size();
   end

endmodule

>>> bench/tb_url_percent_escape_decoder.sv
`timescale 1ns / 1ps

module tb_url_percent_escape_decoder;

   localparam int RandomItems = 136;
   localparam int IdleLimit   = 1000;
   localparam int HoldCycles  = 120;
   localparam int NumDirected = 24;

   // Plain bytes, good and broken escapes, and every way a space can end one.
   localparam logic [7:0] DirectedBytes [NumDirected] = '{
      upd_pkg::CH_PLUS, 8'h00, 8'hFF,
      upd_pkg::CH_PERCENT, "2", "1",
      upd_pkg::CH_PERCENT, "5", "D",
      upd_pkg::CH_PERCENT, "3", "a",
      upd_pkg::CH_PERCENT, "2", upd_pkg::CH_PERCENT,
      upd_pkg::CH_PLUS,
      upd_pkg::CH_PERCENT, "5", upd_pkg::CH_SPACE,
      upd_pkg::CH_PERCENT, upd_pkg::CH_SPACE,
      upd_pkg::CH_PERCENT, "2", "0"
   };

   localparam logic [7:0] HexDigits [16] = '{
      "0", "1", "2", "3", "4", "5", "6", "7",
      "8", "9", "A", "B", "C", "D", "E", "F"
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   logic req_fire;
   int   mismatch_count;
   int   awaited_count;
   int   sent_count = 0;
   int   idle_cycles = 0;
   bit   hold_done = 0;

   url_percent_escape_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   query_decode_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready && !reset;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Mostly back to back, sometimes a short gap, now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic bit in_busy_stretch();
      return sent_count >= 100 && sent_count < 130;
   endfunction

   task automatic send_raw_byte(input logic [7:0] b);
      int gap;
      gap = in_busy_stretch() ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do begin
         @(negedge clock);
      end while (!req_fire);
      sent_count++;
   endtask

   // Receiver: random stalls, plus one long hold while the sender keeps going.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= 60) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1;
            rsp_tready <= 1'b1;
         end else if (in_busy_stretch()) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      int kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumDirected; i++) begin
         send_raw_byte(DirectedBytes[i]);
      end

      while (sent_count < NumDirected + RandomItems) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // Escape with a valid first digit; the pair often hits a reserved code.
            send_raw_byte(upd_pkg::CH_PERCENT);
            send_raw_byte(8'("2") + 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) < 7) begin
               send_raw_byte(HexDigits[$urandom_range(0, 15)]);
            end else begin
               send_raw_byte(8'($urandom_range(0, 255)));
            end
         end else if (kind < 50) begin
            send_raw_byte(upd_pkg::CH_PLUS);
         end else if (kind < 60) begin
            send_raw_byte(upd_pkg::CH_SPACE);
         end else if (kind < 68) begin
            send_raw_byte(upd_pkg::CH_PERCENT);
            send_raw_byte(8'($urandom_range(0, 255)));
         end else begin
            send_raw_byte(8'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;

      while (awaited_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
src/upd_pkg.sv
src/upd_decode.sv
src/url_percent_escape_decoder.sv
src/upd_checker.sv
bench/query_decode_checker.sv
bench/tb_url_percent_escape_decoder.sv
